@@ rtl/apm_pkg.sv @@
package apm_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int BUFFER_MAX_DEF     = 4096;
  localparam int LOG_TABLE_BITS_DEF = 6;

  localparam int FRAC_BITS   = 20;
  localparam int LEVEL_BITS  = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int SCALE_BITS  = 17;

  localparam logic [LEVEL_BITS-1:0] ONE_Q20      = 21'd1048576;
  localparam logic [LEVEL_BITS-1:0] DECAY_RESET  = 21'd73;
  localparam logic [SCALE_BITS-1:0] LOG10_2_DIV3 = 17'd105218;

  // Q20 log2 of 1 + idx / 2^tab_bits, by repeated squaring; constant arguments only.
  function automatic logic [FRAC_BITS-1:0] frac_log2(input int idx, input int tab_bits);
    logic [63:0] z;
    logic [FRAC_BITS-1:0] r;
    z = (64'd1 << tab_bits) + 64'(idx);
    z = z << (30 - tab_bits);
    r = '0;
    for (int k = 0; k < FRAC_BITS; k++) begin
      z = (z * z) >> 30;
      r = {r[FRAC_BITS-2:0], 1'b0};
      if (z >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        z = z >> 1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/apm_if.sv @@
interface apm_sample_if import apm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface apm_level_if import apm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;

  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

@@ rtl/apm_queue.sv @@
module apm_queue import apm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/apm_front.sv @@
module apm_front import apm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int BUFFER_MAX  = BUFFER_MAX_DEF,
  parameter int PEAK_W      = SAMPLE_BITS - 1,
  parameter int CNT_W       = $clog2(BUFFER_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  apm_sample_if.sink              samples,
  output logic                    push,
  output logic [PEAK_W+CNT_W-1:0] push_data,
  input  logic                    full
);

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] neg;
  logic [PEAK_W-1:0]      mag;
  logic [PEAK_W-1:0]      peak;
  logic [PEAK_W-1:0]      peak_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   xfer;

  assign samples.ready = !full;
  assign xfer          = samples.valid && samples.ready;

  always_comb begin
    raw = samples.sample;
    neg = ~raw + SAMPLE_BITS'(1);
    if (raw[SAMPLE_BITS-1]) begin
      mag = neg[SAMPLE_BITS-1] ? '1 : neg[PEAK_W-1:0];
    end else begin
      mag = raw[PEAK_W-1:0];
    end
    peak_next  = (mag > peak) ? mag : peak;
    count_next = (count < CNT_W'(BUFFER_MAX)) ? count + 1'b1 : count;
  end

  assign push      = xfer && samples.last;
  assign push_data = {peak_next, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      peak  <= '0;
      count <= '0;
    end else if (xfer) begin
      if (samples.last) begin
        peak  <= '0;
        count <= '0;
      end else begin
        peak  <= peak_next;
        count <= count_next;
      end
    end
  end

endmodule

@@ rtl/apm_back.sv @@
module apm_back import apm_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int BUFFER_MAX     = BUFFER_MAX_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
  parameter int PEAK_W         = SAMPLE_BITS - 1,
  parameter int CNT_W          = $clog2(BUFFER_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [LEVEL_BITS-1:0]   cfg_wr_data,
  input  logic                    empty,
  input  logic [PEAK_W+CNT_W-1:0] head,
  output logic                    pop,
  apm_level_if.source             levels
);

  localparam int E_W    = $clog2(SAMPLE_BITS);
  localparam int LG_W   = E_W + FRAC_BITS;
  localparam int TAB_N  = 1 << LOG_TABLE_BITS;
  localparam int PROD_W = LG_W + SCALE_BITS;
  localparam int DROP_W = PROD_W - FRAC_BITS;
  localparam int CMP_W  = DROP_W + 1;
  localparam int DEC_W  = CNT_W + LEVEL_BITS;
  localparam int GATE_W = PEAK_W + 10;
  localparam int EXT_W  = PEAK_W + LOG_TABLE_BITS;

  localparam logic [LG_W-1:0]   TOP_LG   = {E_W'(SAMPLE_BITS - 1), {FRAC_BITS{1'b0}}};
  localparam logic [GATE_W-1:0] GATE_LIM = GATE_W'(1) << PEAK_W;
  localparam logic [PROD_W-1:0] ROUND    = PROD_W'(1) << (FRAC_BITS - 1);

  logic [FRAC_BITS-1:0] log_tab [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    assign log_tab[i] = frac_log2(i, LOG_TABLE_BITS);
  end

  logic [LEVEL_BITS-1:0]     decay_step;
  logic [LEVEL_BITS-1:0]     shown_level;
  logic                      adv;

  logic [PEAK_W-1:0]         h_peak;
  logic [CNT_W-1:0]          h_cnt;
  logic [GATE_W-1:0]         h_p1000;
  logic                      h_gate;
  logic [E_W-1:0]            h_e;
  logic [EXT_W-1:0]          h_shift;
  logic [LOG_TABLE_BITS-1:0] h_idx;
  logic [LG_W-1:0]           h_lg;
  logic [DEC_W-1:0]          h_dec;

  logic                      s1_vld;
  logic                      s1_gate;
  logic [LG_W-1:0]           s1_lg;
  logic [DEC_W-1:0]          s1_dec;
  logic [LG_W-1:0]           s1_d;
  logic [PROD_W-1:0]         s1_prod;

  logic                      s2_vld;
  logic                      s2_gate;
  logic [DROP_W-1:0]         s2_drop;
  logic [DEC_W-1:0]          s2_dec;
  logic [LEVEL_BITS-1:0]     s2_v;
  logic [LEVEL_BITS-1:0]     s2_fall;
  logic [LEVEL_BITS-1:0]     s2_lvl;

  logic                      out_vld;
  logic [LEVEL_BITS-1:0]     out_level;

  assign adv          = !out_vld || levels.ready;
  assign pop          = adv && !empty;
  assign levels.valid = out_vld;
  assign levels.level = out_level;

  // head of queue: silence gate, leading one, mantissa lookup, decay product
  always_comb begin
    h_peak  = head[PEAK_W+CNT_W-1:CNT_W];
    h_cnt   = head[CNT_W-1:0];
    h_p1000 = GATE_W'(h_peak) * GATE_W'(1000);
    h_gate  = (h_p1000 <= GATE_LIM);
    h_e     = '0;
    for (int b = 0; b < PEAK_W; b++) begin
      if (h_peak[b]) begin
        h_e = E_W'(b);
      end
    end
    h_shift = {h_peak, {LOG_TABLE_BITS{1'b0}}} >> h_e;
    h_idx   = h_shift[LOG_TABLE_BITS-1:0];
    h_lg    = {h_e, log_tab[h_idx]};
    h_dec   = DEC_W'(h_cnt) * DEC_W'(decay_step);
  end

  always_comb begin
    s1_d    = TOP_LG - s1_lg;
    s1_prod = PROD_W'(s1_d) * PROD_W'(LOG10_2_DIV3) + ROUND;
  end

  always_comb begin
    if (s2_gate || (CMP_W'(s2_drop) >= CMP_W'(ONE_Q20))) begin
      s2_v = '0;
    end else begin
      s2_v = ONE_Q20 - LEVEL_BITS'(s2_drop);
    end
    if (DEC_W'(shown_level) > s2_dec) begin
      s2_fall = shown_level - s2_dec[LEVEL_BITS-1:0];
    end else begin
      s2_fall = '0;
    end
    s2_lvl = (s2_v > s2_fall) ? s2_v : s2_fall;
    if (s2_lvl > ONE_Q20) begin
      s2_lvl = ONE_Q20;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_step  <= DECAY_RESET;
      shown_level <= '0;
      s1_vld      <= 1'b0;
      s2_vld      <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        decay_step <= cfg_wr_data;
      end
      if (adv) begin
        s1_vld  <= !empty;
        s2_vld  <= s1_vld;
        out_vld <= s2_vld;
        if (s2_vld) begin
          shown_level <= s2_lvl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_gate   <= h_gate;
      s1_lg     <= h_lg;
      s1_dec    <= h_dec;
      s2_gate   <= s1_gate;
      s2_drop   <= s1_prod[PROD_W-1:FRAC_BITS];
      s2_dec    <= s1_dec;
      out_level <= s2_lvl;
    end
  end

endmodule

@@ rtl/audio_peak_meter_db_release_core.sv @@
// Peak meter with a dB scale and a linear release.
// samples: valid/ready channel of signed samples; last closes a buffer.
// levels: valid/ready channel, one Q20 level (0..1.0) per closed buffer.
// cfg_wr_en/cfg_wr_data: writes decay_step, the per-sample fall of the level.
// Throughput: one sample transfer per clock. The front tracks peak and count
// per sample; buffer summaries go through a 4-entry queue to a three-stage
// back end (log lookup and decay multiply, scale multiply, release/max),
// which also finishes one buffer per clock.
// A buffer is queued at its last sample, then passes the s1, s2, out registers.
// When levels stalls, the back end holds; once the queue fills, samples.ready
// drops until the receiver takes a level.
// Reset: peak, count and shown level clear, decay_step returns to 73,
// the queue and pipeline empty. No clearing pass; ready right after reset.
module audio_peak_meter_db_release_core import apm_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int BUFFER_MAX     = BUFFER_MAX_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LEVEL_BITS-1:0] cfg_wr_data,
  apm_sample_if.sink            samples,
  apm_level_if.source           levels
);

  localparam int PEAK_W  = SAMPLE_BITS - 1;
  localparam int CNT_W   = $clog2(BUFFER_MAX + 1);
  localparam int ENTRY_W = PEAK_W + CNT_W;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               full;
  logic               pop;
  logic [ENTRY_W-1:0] head;
  logic               empty;

  apm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .BUFFER_MAX  (BUFFER_MAX),
    .PEAK_W      (PEAK_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  apm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  apm_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .BUFFER_MAX     (BUFFER_MAX),
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .PEAK_W         (PEAK_W),
    .CNT_W          (CNT_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .levels      (levels)
  );

endmodule
